@@ rtl/pcxrle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared codes and types for the PCX run-length palette decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  // Command codes carried on s_tuser
  typedef enum logic [1:0] {
    CMD_PALETTE = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_START   = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_LINE_BYTES   = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  localparam int CfgDataW = 17;

  // Run marker: top two bits set, count in the low six bits
  localparam logic [7:0] RUN_MARK = 8'hC0;
  localparam logic [7:0] RUN_MASK = 8'h3F;

  // One decoded pixel on its way out
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_run;
    logic       image_done;
  } pixel_t;

endpackage

@@ rtl/pcx_rle_palette_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder
// Decodes an 8-bit single-plane PCX run-length stream into RGB pixels.
// ----------------------------------------------------------------------------
// Usage: palette writes, start-of-image commands and run markers are taken
// without leaving the idle state. A literal byte, and the value byte of a
// run of n, go through a palette read, one decode step per index, and the
// release of the pixel held back so that it can be marked as the last of
// its byte. The single read port of the palette memory is read once per
// stream byte; the decode loop steps one index per cycle while the output
// is free. Output backpressure adds stall cycles. The palette has no reset
// and must be written before an entry is used.
// ----------------------------------------------------------------------------
module pcx_rle_palette_decoder
  import pcxrle_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  // Input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [39:0]         s_tdata,   // data_byte[7:0], palette_index[15:8],
                                         // palette_color[39:16]
  input  logic [1:0]          s_tuser,   // command[1:0]
  // Output stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic                m_tlast,   // last_of_run
  output logic                m_tuser,   // image_done
  // Configuration
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int PalAw = $clog2(PALETTE_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Configuration registers
  logic [16:0] image_width;
  logic [15:0] line_bytes;
  logic [16:0] image_height;

  // Decoder state
  state_t      state;
  logic        run_pending;
  logic [5:0]  pending_count;
  logic [5:0]  steps;
  logic [15:0] column_position;
  logic [16:0] line_position;
  logic        frame_finished;

  // Held pixel and output register
  logic        hold_valid;
  pixel_t      hold_pix;
  logic        out_valid;
  pixel_t      out_pix;

  // Palette memory
  logic [23:0] color_table [PALETTE_DEPTH];
  logic [23:0] color_q;

  // Input fields
  cmd_t        command;
  logic [7:0]  data_byte;
  logic [7:0]  palette_index;
  logic [23:0] palette_color;
  logic        s_accept;

  assign command       = cmd_t'(s_tuser);
  assign data_byte     = s_tdata[7:0];
  assign palette_index = s_tdata[15:8];
  assign palette_color = s_tdata[39:16];
  assign s_tready      = (state == ST_IDLE);
  assign s_accept      = s_tvalid && s_tready;

  // Decode step combinational terms
  logic [15:0] next_col;
  logic        line_end;
  logic        last_line;
  logic        visible;
  logic        last_visible;
  logic        out_free;
  logic        step_go;
  logic        finish;
  logic        finish_go;
  logic        out_load;
  pixel_t      new_pix;

  always_comb begin
    next_col     = column_position + 16'd1;
    line_end     = (next_col == line_bytes);
    last_line    = ((line_position + 17'd1) == image_height);
    visible      = ({1'b0, column_position} < image_width);
    last_visible = line_end || (({1'b0, column_position} + 17'd1) == image_width);
    out_free     = !out_valid || m_tready;
    finish       = (state == ST_RUN) && ((steps == 6'd0) || frame_finished);
    step_go      = (state == ST_RUN) && !finish && (!hold_valid || out_free);
    finish_go    = finish && (!hold_valid || out_free);
    out_load     = hold_valid && ((step_go && visible) || finish_go);
    new_pix.red         = color_q[23:16];
    new_pix.green       = color_q[15:8];
    new_pix.blue        = color_q[7:0];
    new_pix.last_of_run = 1'b0;
    new_pix.image_done  = last_visible && last_line;
  end

  // Write palette entries and read one per stream byte
  always_ff @(posedge clk) begin
    if (s_accept && (command == CMD_PALETTE)) begin
      color_table[palette_index[PalAw-1:0]] <= palette_color;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && (command == CMD_BYTE)) begin
      color_q <= color_table[data_byte[PalAw-1:0]];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 17'd1;
      line_bytes   <= 16'd1;
      image_height <= 17'd1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_LINE_BYTES:   line_bytes   <= cfg_data[15:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: accept items, step the decode loop, hold and release pixels
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      run_pending     <= 1'b0;
      pending_count   <= 6'd0;
      steps           <= 6'd0;
      column_position <= 16'd0;
      line_position   <= 17'd0;
      frame_finished  <= 1'b0;
      hold_valid      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      // load or drain the output register
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_accept) begin
            unique case (command)
              CMD_START: begin
                run_pending     <= 1'b0;
                pending_count   <= 6'd0;
                column_position <= 16'd0;
                line_position   <= 17'd0;
                frame_finished  <= 1'b0;
              end
              CMD_BYTE: begin
                if (!frame_finished) begin
                  if (run_pending) begin
                    run_pending   <= 1'b0;
                    steps         <= pending_count;
                    pending_count <= 6'd0;
                    state         <= ST_RUN;
                  end else if ((data_byte & RUN_MARK) == RUN_MARK) begin
                    run_pending   <= 1'b1;
                    pending_count <= data_byte[5:0] & RUN_MASK[5:0];
                  end else begin
                    steps <= 6'd1;
                    state <= ST_RUN;
                  end
                end
              end
              default: ;
            endcase
          end
        end

        ST_RUN: begin
          if (step_go) begin
            steps <= steps - 6'd1;
            if (visible) begin
              // release the earlier pixel, keep the new one back
              if (hold_valid) begin
                out_pix <= hold_pix;
              end
              hold_pix   <= new_pix;
              hold_valid <= 1'b1;
            end
            if (line_end) begin
              column_position <= 16'd0;
              line_position   <= line_position + 17'd1;
              if (last_line) begin
                frame_finished <= 1'b1;
              end
            end else begin
              column_position <= next_col;
            end
          end else if (finish_go) begin
            // flush the held pixel as the last of this byte
            if (hold_valid) begin
              out_pix    <= '{red:         hold_pix.red,
                              green:       hold_pix.green,
                              blue:        hold_pix.blue,
                              last_of_run: 1'b1,
                              image_done:  hold_pix.image_done};
              hold_valid <= 1'b0;
            end
            steps <= 6'd0;
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_pix.blue, out_pix.green, out_pix.red};
  assign m_tlast  = out_pix.last_of_run;
  assign m_tuser  = out_pix.image_done;

endmodule

@@ rtl/pcxrle_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcxrle_checker
// Port-level checks for the PCX run-length palette decoder.
// ----------------------------------------------------------------------------
module pcxrle_checker
  import pcxrle_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // Leave reset idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

  // Only stream bytes start a decode; other commands keep the input open
  a_nonbyte_ready: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser != CMD_BYTE)) |=> s_tready)
    else $error("input stalled after a non-byte command");

  // A new pixel comes only out of a decode in progress
  a_pixel_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("pixel appeared without a decode");

  // The final pixel of an image ends its byte's output
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("image end pixel not marked last of run");

  // Hold a stalled transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    else $error("output transaction changed while stalled");

endmodule

bind pcx_rle_palette_decoder pcxrle_checker u_pcxrle_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
